/* rtl/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, constants and helpers of the 1-Wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // Field and counter widths
  localparam int unsigned OPCODE_W       = 2;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_DATA_W     = 10;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned TICK_W         = 10;
  localparam int unsigned BITS_PER_BYTE  = 8;
  localparam int unsigned BIT_IDX_W      = 3;
  localparam int unsigned CMP_W          = 17;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0] CNT_MAX  = {TICK_W{1'b1}};

  // Reset values of the timing registers
  localparam logic [CFG_DATA_W-1:0] RST_RESET_LOW   = CFG_DATA_W'(480);
  localparam logic [CFG_DATA_W-1:0] RST_PRES_WAIT   = CFG_DATA_W'(80);
  localparam logic [CFG_DATA_W-1:0] RST_RESET_RECOV = CFG_DATA_W'(400);
  localparam logic [CFG_DATA_W-1:0] RST_SHORT_LOW   = CFG_DATA_W'(1);
  localparam logic [CFG_DATA_W-1:0] RST_LONG_LOW    = CFG_DATA_W'(50);
  localparam logic [CFG_DATA_W-1:0] RST_SLOT_RECOV  = CFG_DATA_W'(50);

  // Command opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  // Timing register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW   = 3'd0,
    CFG_PRES_WAIT   = 3'd1,
    CFG_RESET_RECOV = 3'd2,
    CFG_SHORT_LOW   = 3'd3,
    CFG_LONG_LOW    = 3'd4,
    CFG_SLOT_RECOV  = 3'd5
  } cfg_idx_e;

  // Bus phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_RST_LOW   = 8'b0000_0010,
    PH_RST_WAIT  = 8'b0000_0100,
    PH_RST_RECOV = 8'b0000_1000,
    PH_WR_LOW    = 8'b0001_0000,
    PH_WR_REL    = 8'b0010_0000,
    PH_RD_LOW    = 8'b0100_0000,
    PH_RD_REL    = 8'b1000_0000
  } phase_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic              start_reset;
    logic              start_write;
    logic              start_read;
    logic [BYTE_W-1:0] write_byte;
    logic              line_level;
  } item_t;

  // Low time of zero acts as one tick
  function automatic logic [CFG_DATA_W-1:0] at_least_one(input logic [CFG_DATA_W-1:0] v);
    at_least_one = (v == '0) ? CFG_DATA_W'(1) : v;
  endfunction

  // Count reached the target, with targets beyond the counter range saturating
  function automatic logic tick_hit(input logic [TICK_W-1:0]     cnt,
                                    input logic [CFG_DATA_W-1:0] target);
    tick_hit = (CMP_W'(cnt) >= CMP_W'(target)) || (cnt == CNT_MAX);
  endfunction

endpackage

`default_nettype wire

/* rtl/owbm_if.sv */
// ----------------------------------------------------------------------------
// owbm_if
// Channel interfaces of the 1-Wire bus master: command, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [owbm_pkg::OPCODE_W-1:0] opcode;
  logic [owbm_pkg::BYTE_W-1:0]   write_byte;
  logic                          line_level;

  modport source (output valid, output opcode, output write_byte, output line_level,
                  input ready);
  modport sink   (input valid, input opcode, input write_byte, input line_level,
                  output ready);
endinterface

interface owbm_res_if;
  logic                        valid;
  logic                        ready;
  logic                        drive_low;
  logic                        busy_res;
  logic                        done_res;
  logic                        presence;
  logic [owbm_pkg::BYTE_W-1:0] read_byte;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output read_byte, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input read_byte, output ready);
endinterface

interface owbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [owbm_pkg::CFG_IDX_W-1:0]  index;
  logic [owbm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/owbm_front.sv */
// ----------------------------------------------------------------------------
// owbm_front
// Command front end: accepts beats and classifies the opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_front (
  owbm_cmd_if.sink          cmd_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output owbm_pkg::item_t   push_item_o
);

  // Pass the handshake straight to the queue
  assign push_valid_o = cmd_i.valid;
  assign cmd_i.ready  = push_ready_i;

  // Classify the opcode into start requests
  always_comb begin
    push_item_o             = '0;
    push_item_o.write_byte  = cmd_i.write_byte;
    push_item_o.line_level  = cmd_i.line_level;
    unique case (owbm_pkg::opcode_e'(cmd_i.opcode))
      owbm_pkg::OP_TICK:  push_item_o.start_reset = 1'b0;
      owbm_pkg::OP_RESET: push_item_o.start_reset = 1'b1;
      owbm_pkg::OP_WRITE: push_item_o.start_write = 1'b1;
      owbm_pkg::OP_READ:  push_item_o.start_read  = 1'b1;
      default:            push_item_o.start_reset = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/owbm_queue.sv */
// ----------------------------------------------------------------------------
// owbm_queue
// Short queue of classified items between the front end and the bus engine.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  owbm_pkg::item_t   push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output owbm_pkg::item_t   pop_item_o
);

  owbm_pkg::item_t                  mem_q [owbm_pkg::QUEUE_DEPTH];
  logic [owbm_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [owbm_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [owbm_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                             push, pop;

  assign push_ready_o = (count_q != owbm_pkg::QCNT_W'(owbm_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == owbm_pkg::QPTR_W'(owbm_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + owbm_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == owbm_pkg::QPTR_W'(owbm_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + owbm_pkg::QPTR_W'(1);
    end
    priority if (push && !pop) begin
      count_d = count_q + owbm_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - owbm_pkg::QCNT_W'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/owbm_back.sv */
// ----------------------------------------------------------------------------
// owbm_back
// Bus engine: timing registers, phase sequencer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  owbm_cfg_if.sink          cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  owbm_pkg::item_t   pop_item_i,
  owbm_res_if.source        res_o
);

  localparam int unsigned DW = owbm_pkg::CFG_DATA_W;
  localparam int unsigned TW = owbm_pkg::TICK_W;
  localparam int unsigned BW = owbm_pkg::BYTE_W;
  localparam int unsigned IW = owbm_pkg::BIT_IDX_W;

  // Timing registers
  logic [DW-1:0] reset_low_q, pres_wait_q, reset_recov_q;
  logic [DW-1:0] short_low_q, long_low_q, slot_recov_q;

  // Sequencer state
  owbm_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]    cnt_q, cnt_d, cnt_inc;
  logic [IW-1:0]    bit_q, bit_d;
  logic [BW-1:0]    shift_q, shift_d, shift_rd;
  logic             pres_q, pres_d;
  logic [BW-1:0]    latch_q, latch_d;
  logic             done;
  logic             cur_bit;
  logic             last_bit;
  logic             step;

  // Result register
  logic             res_valid_q;
  logic             res_drive_q, res_busy_q, res_done_q, res_pres_q;
  logic [BW-1:0]    res_byte_q;

  assign cfg_i.ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q   <= owbm_pkg::RST_RESET_LOW;
      pres_wait_q   <= owbm_pkg::RST_PRES_WAIT;
      reset_recov_q <= owbm_pkg::RST_RESET_RECOV;
      short_low_q   <= owbm_pkg::RST_SHORT_LOW;
      long_low_q    <= owbm_pkg::RST_LONG_LOW;
      slot_recov_q  <= owbm_pkg::RST_SLOT_RECOV;
    end else if (cfg_i.valid) begin
      unique case (owbm_pkg::cfg_idx_e'(cfg_i.index))
        owbm_pkg::CFG_RESET_LOW:   reset_low_q   <= cfg_i.data;
        owbm_pkg::CFG_PRES_WAIT:   pres_wait_q   <= cfg_i.data;
        owbm_pkg::CFG_RESET_RECOV: reset_recov_q <= cfg_i.data;
        owbm_pkg::CFG_SHORT_LOW:   short_low_q   <= cfg_i.data;
        owbm_pkg::CFG_LONG_LOW:    long_low_q    <= cfg_i.data;
        owbm_pkg::CFG_SLOT_RECOV:  slot_recov_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Step when a beat waits and the result register is free
  assign pop_ready_o = !res_valid_q || res_o.ready;
  assign step        = pop_valid_i && pop_ready_o;

  assign cnt_inc  = (cnt_q != owbm_pkg::CNT_MAX) ? cnt_q + TW'(1) : cnt_q;
  assign cur_bit  = shift_q[bit_q];
  assign last_bit = ((IW + 1)'(bit_q) + (IW + 1)'(1)) >= (IW + 1)'(owbm_pkg::BITS_PER_BYTE);

  // Sample the read bit on the first released tick of a read slot
  always_comb begin
    shift_rd = shift_q;
    if (cnt_q == '0 && pop_item_i.line_level) begin
      shift_rd[bit_q] = 1'b1;
    end
  end

  // Phase sequencer
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    latch_d = latch_q;
    done    = 1'b0;
    unique case (phase_q)
      owbm_pkg::PH_IDLE: begin
        cnt_d = '0;
        bit_d = '0;
        priority if (pop_item_i.start_reset) begin
          phase_d = owbm_pkg::PH_RST_LOW;
          pres_d  = 1'b0;
        end else if (pop_item_i.start_write) begin
          phase_d = owbm_pkg::PH_WR_LOW;
          shift_d = pop_item_i.write_byte;
        end else if (pop_item_i.start_read) begin
          phase_d = owbm_pkg::PH_RD_LOW;
          shift_d = '0;
        end else begin
          phase_d = owbm_pkg::PH_IDLE;
        end
      end
      owbm_pkg::PH_RST_LOW: begin
        cnt_d = cnt_inc;
        if (owbm_pkg::tick_hit(cnt_inc, owbm_pkg::at_least_one(reset_low_q))) begin
          phase_d = owbm_pkg::PH_RST_WAIT;
          cnt_d   = '0;
        end
      end
      owbm_pkg::PH_RST_WAIT: begin
        cnt_d = cnt_inc;
        if (owbm_pkg::tick_hit(cnt_inc, owbm_pkg::at_least_one(pres_wait_q))) begin
          pres_d = !pop_item_i.line_level;
          cnt_d  = '0;
          if (reset_recov_q == '0) begin
            phase_d = owbm_pkg::PH_IDLE;
            done    = 1'b1;
          end else begin
            phase_d = owbm_pkg::PH_RST_RECOV;
          end
        end
      end
      owbm_pkg::PH_RST_RECOV: begin
        cnt_d = cnt_inc;
        if (owbm_pkg::tick_hit(cnt_inc, reset_recov_q)) begin
          phase_d = owbm_pkg::PH_IDLE;
          cnt_d   = '0;
          done    = 1'b1;
        end
      end
      owbm_pkg::PH_WR_LOW: begin
        cnt_d = cnt_inc;
        if (owbm_pkg::tick_hit(cnt_inc, owbm_pkg::at_least_one(cur_bit ? short_low_q
                                                                          : long_low_q))) begin
          phase_d = owbm_pkg::PH_WR_REL;
          cnt_d   = '0;
        end
      end
      owbm_pkg::PH_RD_LOW: begin
        cnt_d = cnt_inc;
        if (owbm_pkg::tick_hit(cnt_inc, owbm_pkg::at_least_one(short_low_q))) begin
          phase_d = owbm_pkg::PH_RD_REL;
          cnt_d   = '0;
        end
      end
      owbm_pkg::PH_WR_REL: begin
        cnt_d = cnt_inc;
        // a write-zero slot releases for exactly one tick
        if (owbm_pkg::tick_hit(cnt_inc, cur_bit ? owbm_pkg::at_least_one(slot_recov_q)
                                                : DW'(1))) begin
          cnt_d = '0;
          if (last_bit) begin
            phase_d = owbm_pkg::PH_IDLE;
            bit_d   = '0;
            done    = 1'b1;
          end else begin
            phase_d = owbm_pkg::PH_WR_LOW;
            bit_d   = bit_q + IW'(1);
          end
        end
      end
      owbm_pkg::PH_RD_REL: begin
        cnt_d   = cnt_inc;
        shift_d = shift_rd;
        if (owbm_pkg::tick_hit(cnt_inc, owbm_pkg::at_least_one(slot_recov_q))) begin
          cnt_d = '0;
          if (last_bit) begin
            latch_d = shift_rd;
            phase_d = owbm_pkg::PH_IDLE;
            bit_d   = '0;
            done    = 1'b1;
          end else begin
            phase_d = owbm_pkg::PH_RD_LOW;
            bit_d   = bit_q + IW'(1);
          end
        end
      end
      default: begin
        phase_d = owbm_pkg::PH_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // Hold sequencer state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      latch_q <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      latch_q <= latch_d;
    end
  end

  // Result beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Load the result payload from the next state
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_drive_q <= (phase_d == owbm_pkg::PH_RST_LOW) || (phase_d == owbm_pkg::PH_WR_LOW) ||
                     (phase_d == owbm_pkg::PH_RD_LOW);
      res_busy_q  <= (phase_d != owbm_pkg::PH_IDLE);
      res_done_q  <= done;
      res_pres_q  <= pres_d;
      res_byte_q  <= latch_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.drive_low = res_drive_q;
  assign res_o.busy_res  = res_busy_q;
  assign res_o.done_res  = res_done_q;
  assign res_o.presence  = res_pres_q;
  assign res_o.read_byte = res_byte_q;

endmodule

`default_nettype wire

/* rtl/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Timed 1-Wire master driven by one command or microsecond tick per beat.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one beat per microsecond: an opcode (tick, bus reset, byte
//   write, byte read), the byte to send and the sampled bus level. Commands
//   that arrive while an operation runs are treated as plain ticks.
//   res_o returns one beat for every command beat: bus drive, busy, done,
//   presence and the last read byte, all showing the state after that beat.
//   cfg_i writes the six timing registers; write only while idle.
// Timing:
//   A command beat passes the queue, then the bus engine's result register.
//   The bus engine retires one beat per cycle while res_o does not stall,
//   so sustained throughput is one beat per clock; the phase sequencer
//   advances once per retired beat.
// Reset and stalls:
//   Reset loads the default timing values, empties the queue and returns the
//   sequencer to idle. When res_o stalls, the two-entry queue keeps taking
//   beats until it fills, then cmd_i.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master (
  input  logic         clk_i,
  input  logic         rst_ni,
  owbm_cmd_if.sink     cmd_i,
  owbm_res_if.source   res_o,
  owbm_cfg_if.sink     cfg_i
);

  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  owbm_pkg::item_t   push_item, pop_item;

  owbm_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  owbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  owbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_o       (res_o)
  );

  // A finished operation always leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.busy_res)
    else $error("done raised while still busy");

  // The bus is only pulled low during an operation
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.drive_low |-> res_o.busy_res)
    else $error("bus driven low while idle");

  // Back-pressure on commands only comes from a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> res_o.valid)
    else $error("command stalled with no result pending");

  // A stalled command beat leaves the queue full at the next edge too
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready && !res_o.ready |=> !cmd_i.ready)
    else $error("queue drained without a result being taken");

endmodule

`default_nettype wire

/* tb/one_wire_bus_master_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Self-checking bench for the 1-Wire bus master. A queue-fed driver sends
// command and tick beats, and a cycle-true model of the bus sequencer
// predicts the result of every accepted beat. A monitor compares each
// result beat with the oldest prediction, field by field. Timing registers
// are reprogrammed between idle phases: all zero, then a run of short
// random settings. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------

module one_wire_bus_master_tb;

  localparam int NUM_REGS      = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 3;
  localparam int OPS_PER_PHASE = 4;

  typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_e;

  typedef struct {
    owbm_pkg::opcode_e           op;
    logic [owbm_pkg::BYTE_W-1:0] wbyte;
    logic                        line;
  } bus_item_t;

  typedef struct packed {
    logic                        drive_low;
    logic                        busy;
    logic                        done;
    logic                        presence;
    logic [owbm_pkg::BYTE_W-1:0] read_byte;
  } master_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  owbm_cmd_if cmd_bus ();
  owbm_res_if res_bus ();
  owbm_cfg_if cfg_bus ();

  one_wire_bus_master DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and result bookkeeping
  bus_item_t   queued_items[$];
  master_res_t due_results[$];
  int          items_queued  = 0;
  int          results_seen  = 0;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles  = 0;

  // Model of the bus sequencer and its timing registers
  logic [owbm_pkg::CFG_DATA_W-1:0] timing [NUM_REGS];
  owbm_pkg::phase_e                bm_phase    = owbm_pkg::PH_IDLE;
  logic [owbm_pkg::TICK_W-1:0]     bm_ticks    = '0;
  logic [owbm_pkg::BIT_IDX_W-1:0]  bm_bit      = '0;
  logic [owbm_pkg::BYTE_W-1:0]     bm_shift    = '0;
  logic                            bm_presence = 1'b0;
  logic [owbm_pkg::BYTE_W-1:0]     bm_read     = '0;

  // A zero low time counts as one tick
  function automatic int floor_one(input logic [owbm_pkg::CFG_DATA_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  // Advance the tick counter, saturating, and report whether target is met
  function automatic bit tick_reached(input int target);
    if (bm_ticks != owbm_pkg::CNT_MAX) begin
      bm_ticks = bm_ticks + 1'b1;
    end
    return int'(bm_ticks) >= target;
  endfunction

  // Apply one beat to the model and return the result it shows
  function automatic master_res_t master_step(input owbm_pkg::opcode_e op,
                                              input logic [owbm_pkg::BYTE_W-1:0] wb,
                                              input logic line);
    master_res_t r;
    int          target;
    logic        done;
    done = 1'b0;
    case (bm_phase)
      owbm_pkg::PH_IDLE: begin
        bm_ticks = '0;
        bm_bit   = '0;
        if (op == owbm_pkg::OP_RESET) begin
          bm_phase    = owbm_pkg::PH_RST_LOW;
          bm_presence = 1'b0;
        end else if (op == owbm_pkg::OP_WRITE) begin
          bm_phase = owbm_pkg::PH_WR_LOW;
          bm_shift = wb;
        end else if (op == owbm_pkg::OP_READ) begin
          bm_phase = owbm_pkg::PH_RD_LOW;
          bm_shift = '0;
        end
      end
      owbm_pkg::PH_RST_LOW: begin
        if (tick_reached(floor_one(timing[owbm_pkg::CFG_RESET_LOW]))) begin
          bm_phase = owbm_pkg::PH_RST_WAIT;
          bm_ticks = '0;
        end
      end
      owbm_pkg::PH_RST_WAIT: begin
        if (tick_reached(floor_one(timing[owbm_pkg::CFG_PRES_WAIT]))) begin
          bm_presence = ~line;
          bm_ticks    = '0;
          if (timing[owbm_pkg::CFG_RESET_RECOV] == '0) begin
            bm_phase = owbm_pkg::PH_IDLE;
            done     = 1'b1;
          end else begin
            bm_phase = owbm_pkg::PH_RST_RECOV;
          end
        end
      end
      owbm_pkg::PH_RST_RECOV: begin
        if (tick_reached(int'(timing[owbm_pkg::CFG_RESET_RECOV]))) begin
          bm_phase = owbm_pkg::PH_IDLE;
          bm_ticks = '0;
          done     = 1'b1;
        end
      end
      owbm_pkg::PH_WR_LOW, owbm_pkg::PH_RD_LOW: begin
        target = (bm_phase == owbm_pkg::PH_WR_LOW && !bm_shift[bm_bit]) ?
                 floor_one(timing[owbm_pkg::CFG_LONG_LOW]) :
                 floor_one(timing[owbm_pkg::CFG_SHORT_LOW]);
        if (tick_reached(target)) begin
          bm_phase = (bm_phase == owbm_pkg::PH_WR_LOW) ? owbm_pkg::PH_WR_REL
                                                       : owbm_pkg::PH_RD_REL;
          bm_ticks = '0;
        end
      end
      owbm_pkg::PH_WR_REL, owbm_pkg::PH_RD_REL: begin
        // sample the bus on the first released tick of a read slot
        if (bm_phase == owbm_pkg::PH_RD_REL && bm_ticks == '0 && line) begin
          bm_shift[bm_bit] = 1'b1;
        end
        target = (bm_phase == owbm_pkg::PH_WR_REL && !bm_shift[bm_bit]) ?
                 1 : floor_one(timing[owbm_pkg::CFG_SLOT_RECOV]);
        if (tick_reached(target)) begin
          bm_ticks = '0;
          if (bm_bit == owbm_pkg::BIT_IDX_W'(owbm_pkg::BITS_PER_BYTE - 1)) begin
            if (bm_phase == owbm_pkg::PH_RD_REL) begin
              bm_read = bm_shift;
            end
            bm_phase = owbm_pkg::PH_IDLE;
            bm_bit   = '0;
            done     = 1'b1;
          end else begin
            bm_bit   = bm_bit + 1'b1;
            bm_phase = (bm_phase == owbm_pkg::PH_WR_REL) ? owbm_pkg::PH_WR_LOW
                                                         : owbm_pkg::PH_RD_LOW;
          end
        end
      end
      default: begin
        bm_phase = owbm_pkg::PH_IDLE;
        bm_ticks = '0;
      end
    endcase
    r.drive_low = (bm_phase == owbm_pkg::PH_RST_LOW) || (bm_phase == owbm_pkg::PH_WR_LOW) ||
                  (bm_phase == owbm_pkg::PH_RD_LOW);
    r.busy      = (bm_phase != owbm_pkg::PH_IDLE);
    r.done      = done;
    r.presence  = bm_presence;
    r.read_byte = bm_read;
    return r;
  endfunction

  // Ticks after the start beat until the operation completes
  function automatic int op_ticks(input owbm_pkg::opcode_e op,
                                  input logic [owbm_pkg::BYTE_W-1:0] wb);
    int n;
    n = 0;
    case (op)
      owbm_pkg::OP_RESET: begin
        n = floor_one(timing[owbm_pkg::CFG_RESET_LOW]) +
            floor_one(timing[owbm_pkg::CFG_PRES_WAIT]) +
            int'(timing[owbm_pkg::CFG_RESET_RECOV]);
      end
      owbm_pkg::OP_WRITE: begin
        for (int b = 0; b < owbm_pkg::BITS_PER_BYTE; b++) begin
          n += wb[b] ? floor_one(timing[owbm_pkg::CFG_SHORT_LOW]) +
                       floor_one(timing[owbm_pkg::CFG_SLOT_RECOV])
                     : floor_one(timing[owbm_pkg::CFG_LONG_LOW]) + 1;
        end
      end
      owbm_pkg::OP_READ: begin
        n = owbm_pkg::BITS_PER_BYTE * (floor_one(timing[owbm_pkg::CFG_SHORT_LOW]) +
                                       floor_one(timing[owbm_pkg::CFG_SLOT_RECOV]));
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic logic pick_line(input line_mode_e lm);
    case (lm)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1));
    endcase
  endfunction

  // Mostly short timings, now and then zero or a longer one
  function automatic logic [owbm_pkg::CFG_DATA_W-1:0] pick_timing();
    case ($urandom_range(9))
      0:       return '0;
      1:       return owbm_pkg::CFG_DATA_W'($urandom_range(7, 12));
      default: return owbm_pkg::CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic push_item(input owbm_pkg::opcode_e op,
                           input logic [owbm_pkg::BYTE_W-1:0] wb, input logic line);
    bus_item_t it;
    it.op    = op;
    it.wbyte = wb;
    it.line  = line;
    queued_items.push_back(it);
    items_queued++;
  endtask

  // Queue a start beat and the ticks that carry the operation to its end;
  // a noisy operation has stray commands among its ticks
  task automatic queue_op(input owbm_pkg::opcode_e op,
                          input logic [owbm_pkg::BYTE_W-1:0] wb,
                          input line_mode_e lm, input bit noisy);
    int n;
    n = op_ticks(op, wb);
    push_item(op, wb, pick_line(lm));
    for (int i = 0; i < n; i++) begin
      push_item((noisy && $urandom_range(7) == 0) ?
                owbm_pkg::opcode_e'($urandom_range(owbm_pkg::OP_TICK, owbm_pkg::OP_READ)) :
                owbm_pkg::OP_TICK,
                owbm_pkg::BYTE_W'($urandom), pick_line(lm));
    end
  endtask

  // Wait for every result, tick the model back to idle if needed, then hold
  task automatic settle();
    do begin
      while (results_seen < items_queued) @(posedge clk_i);
      if (bm_phase != owbm_pkg::PH_IDLE) begin
        push_item(owbm_pkg::OP_TICK, owbm_pkg::BYTE_W'($urandom), 1'($urandom_range(1)));
      end
    end while (results_seen < items_queued);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input owbm_pkg::cfg_idx_e idx,
                           input logic [owbm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    timing[idx] = val;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [owbm_pkg::CFG_DATA_W-1:0] val);
    for (int r = 0; r < NUM_REGS; r++) begin
      write_reg(owbm_pkg::cfg_idx_e'(r), val);
    end
  endtask

  task automatic check_field(input string name, input logic [owbm_pkg::BYTE_W-1:0] want,
                             input logic [owbm_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Command driver: predict each accepted beat, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_cmd
    bus_item_t nxt;
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        due_results.push_back(master_step(owbm_pkg::opcode_e'(cmd_bus.opcode),
                                          cmd_bus.write_byte, cmd_bus.line_level));
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_items.pop_front();
          cmd_bus.valid      <= 1'b1;
          cmd_bus.opcode     <= nxt.op;
          cmd_bus.write_byte <= nxt.wbyte;
          cmd_bus.line_level <= nxt.line;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch_res
    master_res_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: result beat with no prediction due, actual %0h", $time,
                   {res_bus.drive_low, res_bus.busy_res, res_bus.done_res,
                    res_bus.presence, res_bus.read_byte});
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("drive_low", owbm_pkg::BYTE_W'(want.drive_low),
                      owbm_pkg::BYTE_W'(res_bus.drive_low));
          check_field("busy_res", owbm_pkg::BYTE_W'(want.busy),
                      owbm_pkg::BYTE_W'(res_bus.busy_res));
          check_field("done_res", owbm_pkg::BYTE_W'(want.done),
                      owbm_pkg::BYTE_W'(res_bus.done_res));
          check_field("presence", owbm_pkg::BYTE_W'(want.presence),
                      owbm_pkg::BYTE_W'(res_bus.presence));
          check_field("read_byte", want.read_byte, res_bus.read_byte);
        end
        results_seen++;
      end
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst_ni             = 1'b0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.opcode     = owbm_pkg::OP_TICK;
    cmd_bus.write_byte = '0;
    cmd_bus.line_level = 1'b1;
    res_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = owbm_pkg::CFG_RESET_LOW;
    cfg_bus.data       = '0;
    timing[owbm_pkg::CFG_RESET_LOW]   = owbm_pkg::RST_RESET_LOW;
    timing[owbm_pkg::CFG_PRES_WAIT]   = owbm_pkg::RST_PRES_WAIT;
    timing[owbm_pkg::CFG_RESET_RECOV] = owbm_pkg::RST_RESET_RECOV;
    timing[owbm_pkg::CFG_SHORT_LOW]   = owbm_pkg::RST_SHORT_LOW;
    timing[owbm_pkg::CFG_LONG_LOW]    = owbm_pkg::RST_LONG_LOW;
    timing[owbm_pkg::CFG_SLOT_RECOV]  = owbm_pkg::RST_SLOT_RECOV;
    send_idle_pct = 24;
    recv_idle_pct = 76;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default timings: idle ticks only
    push_item(owbm_pkg::OP_TICK, 8'h00, 1'b0);
    push_item(owbm_pkg::OP_TICK, 8'hFF, 1'b1);

    // All zero: low times act as one tick, done on the presence sample
    settle();
    write_all('0);
    queue_op(owbm_pkg::OP_RESET, 8'h00, LINE_LOW, 1'b0);
    queue_op(owbm_pkg::OP_RESET, 8'hFF, LINE_HIGH, 1'b0);
    queue_op(owbm_pkg::OP_WRITE, 8'h00, LINE_RANDOM, 1'b0);
    queue_op(owbm_pkg::OP_WRITE, 8'hFF, LINE_RANDOM, 1'b0);
    queue_op(owbm_pkg::OP_READ, 8'h00, LINE_HIGH, 1'b0);
    queue_op(owbm_pkg::OP_READ, 8'hFF, LINE_LOW, 1'b1);
    queue_op(owbm_pkg::OP_RESET, 8'h3C, LINE_RANDOM, 1'b1);

    // Random timings and operations, mostly complete, some with stray commands
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p < RANDOM_PHASES / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 76;
      end else if (p < 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        write_reg(owbm_pkg::cfg_idx_e'(r), pick_timing());
      end
      for (int k = 0; k < OPS_PER_PHASE; k++) begin
        if ($urandom_range(7) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            push_item(owbm_pkg::OP_TICK, owbm_pkg::BYTE_W'($urandom),
                      1'($urandom_range(1)));
          end
        end
        queue_op(owbm_pkg::opcode_e'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_READ)),
                 owbm_pkg::BYTE_W'($urandom), LINE_RANDOM, $urandom_range(4) == 0);
      end
    end

    // Drain and report
    settle();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
